// ----- src/updatable_bitmap_index_assert.svh -----
// Assertion macros for the bitmap index block.
// Plain text, no dependencies; taken in by `include where assertions are written.
`ifndef UPDATABLE_BITMAP_INDEX_ASSERT_SVH
`define UPDATABLE_BITMAP_INDEX_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UBI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bitmap index: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define UBI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bitmap index: next-cycle check failed");

`endif

// ----- src/ubi_pkg.sv -----
// Shared types and codes of the bitmap index: request functions, status codes,
// configuration register indexes and the sequencer states. No dependencies.
`default_nettype none

package ubi_pkg;

  typedef enum logic [2:0] {
    FN_APPEND     = 3'd0,
    FN_UPDATE     = 3'd1,
    FN_REMOVE     = 3'd2,
    FN_COUNT_VAL  = 3'd3,
    FN_COUNT_SPAN = 3'd4,
    FN_READ       = 3'd5
  } ubi_func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_ERR  = 2'd2
  } ubi_status_e;

  typedef enum logic {
    CFG_ENCODING = 1'b0,
    CFG_CARD     = 1'b1
  } ubi_cfg_e;

  localparam logic [5:0] CARD_RESET = 6'd32;
  localparam logic [5:0] CARD_MIN   = 6'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_APPLY,
    ST_SCAN,
    ST_FINISH
  } ubi_state_e;

endpackage

`default_nettype wire

// ----- src/ubi_row_store.sv -----
// Single-port row word store of the bitmap index, registered read data.
// Used by updatable_bitmap_index; no package dependencies.
`default_nettype none

module ubi_row_store #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- src/updatable_bitmap_index.sv -----
// Updatable bitmap index over up to ROWS rows of VALUES bitmap bits each, in equality or
// range encoding, built on ubi_pkg and one single-port row store (ubi_row_store). One
// request is worked at a time by a small sequencer around that store and one mask unit.
// Update, remove and read search the row's bitmaps in turn for its lowest set bit (up to
// the bitmap count, at most VALUES). Count requests read every appended row once through
// the store's single port. The row store needs no clearing after reset: rows at or
// beyond the fill count read as empty. Rows are never freed; remove only clears a row's
// bits. A result waits in an output register, and the next request is taken while it
// waits.
`default_nettype none
`include "updatable_bitmap_index_assert.svh"

module updatable_bitmap_index #(
  parameter int ROWS   = 4096,
  parameter int VALUES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [11:0] row_id_i,
  input  wire logic [4:0]  value_i,
  input  wire logic [5:0]  span_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [12:0]      row_count_o,
  output logic [4:0]       value_out_o
);

  localparam int AW = $clog2(ROWS);
  localparam int UW = $clog2(ROWS + 1);
  localparam int NW = $clog2(VALUES + 1);
  localparam int BW = $clog2(VALUES);
  localparam int HW = $clog2(VALUES + 64);

  ubi_pkg::ubi_state_e state_q, state_d;

  logic              encoding_mode_q;
  logic [5:0]        cardinality_q;
  logic [UW-1:0]     rows_used_q, rows_used_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;

  logic [2:0]        func_q, func_d;
  logic [11:0]       row_q, row_d;
  logic [4:0]        val_q, val_d;
  logic [5:0]        span_q, span_d;
  logic [NW-1:0]     k_q, k_d;
  logic [UW-1:0]     scan_q, scan_d;
  logic [UW-1:0]     cnt_q, cnt_d;
  logic [VALUES-1:0] mask_q, mask_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [4:0]        res_vout_q, res_vout_d;
  logic [1:0]        out_status_q;
  logic [12:0]       out_count_q;
  logic [4:0]        out_vout_q;

  logic              in_acc;
  logic              out_load;
  logic [NW-1:0]     card, nb;
  logic              arg_err, row_live, point_op, k_done, k_hit;
  logic [AW-1:0]     row_addr;

  logic [HW-1:0]     lo_s, hi_s;
  logic [VALUES-1:0] mask_w;
  logic [VALUES-1:0] bit_val, bit_f, want;
  logic [1:0]        apply_status;
  logic              apply_we;
  logic [VALUES-1:0] apply_word;

  logic              mem_rd, mem_we;
  logic [AW-1:0]     mem_addr;
  logic [VALUES-1:0] mem_wdata, rd_data;

  ubi_row_store #(
    .DEPTH (ROWS),
    .WIDTH (VALUES)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd),
    .wr_en_i   (mem_we),
    .addr_i    (mem_addr),
    .wr_data_i (mem_wdata),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != ubi_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ubi_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);

  // Cardinality saturated to [2, VALUES]; range encoding keeps one bitmap less.
  always_comb begin
    if (cardinality_q < ubi_pkg::CARD_MIN) begin
      card = NW'(ubi_pkg::CARD_MIN);
    end else if (int'(cardinality_q) > VALUES) begin
      card = NW'(VALUES);
    end else begin
      card = NW'(cardinality_q);
    end
    nb = encoding_mode_q ? card - NW'(1) : card;
  end

  assign row_addr = AW'(row_q);
  assign row_live = int'(row_q) < int'(rows_used_q);
  assign point_op = (func_q == ubi_pkg::FN_UPDATE) || (func_q == ubi_pkg::FN_REMOVE) ||
                    (func_q == ubi_pkg::FN_READ);
  assign k_done   = int'(k_q) >= int'(nb);
  assign k_hit    = rd_data[k_q[BW-1:0]];

  always_comb begin
    case (func_q)
      ubi_pkg::FN_APPEND:     arg_err = (int'(rows_used_q) >= ROWS) ||
                                        (int'(val_q) >= int'(card));
      ubi_pkg::FN_UPDATE:     arg_err = (int'(row_q) >= ROWS) || (int'(val_q) >= int'(card));
      ubi_pkg::FN_REMOVE:     arg_err = int'(row_q) >= ROWS;
      ubi_pkg::FN_READ:       arg_err = int'(row_q) >= ROWS;
      ubi_pkg::FN_COUNT_VAL:  arg_err = int'(val_q) >= int'(nb);
      ubi_pkg::FN_COUNT_SPAN: arg_err = int'(val_q) + int'(span_q) > int'(nb);
      default:                arg_err = 1'b1;
    endcase
  end

  // Mask unit: bitmaps lo .. hi-1, shared by decode and apply.
  always_comb begin
    lo_s = HW'(val_q);
    hi_s = HW'(val_q) + HW'(1);
    if (state_q == ubi_pkg::ST_DECODE) begin
      if (func_q == ubi_pkg::FN_APPEND && encoding_mode_q) begin
        hi_s = HW'(nb);
      end else if (func_q == ubi_pkg::FN_COUNT_SPAN) begin
        hi_s = HW'(val_q) + HW'(span_q);
      end
    end else if (state_q == ubi_pkg::ST_APPLY) begin
      if (func_q == ubi_pkg::FN_REMOVE) begin
        lo_s = HW'(k_q);
        hi_s = HW'(nb);
      end else if (int'(val_q) > int'(k_q)) begin
        lo_s = HW'(k_q);
        hi_s = HW'(val_q);
      end else begin
        lo_s = HW'(val_q);
        hi_s = HW'(k_q);
      end
    end
    for (int i = 0; i < VALUES; i++) begin
      mask_w[i] = (i >= int'(lo_s)) && (i < int'(hi_s));
    end
  end

  assign bit_val = VALUES'(1) << val_q;
  assign bit_f   = VALUES'(1) << k_q;
  assign want    = (int'(val_q) > int'(k_q)) ? mask_w : '0;

  // Row edit once the current value (k_q) is known.
  always_comb begin
    apply_status = ubi_pkg::STAT_OK;
    apply_we     = 1'b0;
    apply_word   = rd_data;
    case (func_q)
      ubi_pkg::FN_READ: begin
        apply_status = ubi_pkg::STAT_OK;
      end
      ubi_pkg::FN_UPDATE: begin
        if (int'(val_q) == int'(k_q)) begin
          apply_status = ubi_pkg::STAT_NONE;
        end else if (!encoding_mode_q) begin
          if ((rd_data & bit_val) != '0) begin
            apply_status = ubi_pkg::STAT_NONE;
          end else begin
            apply_we   = 1'b1;
            apply_word = rd_data ^ (bit_val | bit_f);
          end
        end else if ((rd_data & mask_w) != want) begin
          apply_status = ubi_pkg::STAT_NONE;
        end else begin
          apply_we   = 1'b1;
          apply_word = rd_data ^ mask_w;
        end
      end
      ubi_pkg::FN_REMOVE: begin
        if (!encoding_mode_q) begin
          apply_we   = 1'b1;
          apply_word = rd_data & ~bit_f;
        end else if ((rd_data & mask_w) != mask_w) begin
          apply_status = ubi_pkg::STAT_NONE;
        end else begin
          apply_we   = 1'b1;
          apply_word = rd_data & ~mask_w;
        end
      end
      default: begin
        apply_status = ubi_pkg::STAT_ERR;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ubi_pkg::ST_IDLE: begin
        if (in_acc) state_d = ubi_pkg::ST_DECODE;
      end
      ubi_pkg::ST_DECODE: begin
        if (arg_err || func_q == ubi_pkg::FN_APPEND) begin
          state_d = ubi_pkg::ST_FINISH;
        end else if (point_op) begin
          state_d = row_live ? ubi_pkg::ST_FIND : ubi_pkg::ST_FINISH;
        end else begin
          state_d = ubi_pkg::ST_SCAN;
        end
      end
      ubi_pkg::ST_FIND: begin
        if (k_done) begin
          state_d = ubi_pkg::ST_FINISH;
        end else if (k_hit) begin
          state_d = ubi_pkg::ST_APPLY;
        end
      end
      ubi_pkg::ST_APPLY: begin
        state_d = ubi_pkg::ST_FINISH;
      end
      ubi_pkg::ST_SCAN: begin
        if (scan_q == rows_used_q && !pend_q) state_d = ubi_pkg::ST_FINISH;
      end
      ubi_pkg::ST_FINISH: begin
        if (out_load) state_d = ubi_pkg::ST_IDLE;
      end
      default: begin
        state_d = ubi_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and store control.
  always_comb begin
    rows_used_d  = rows_used_q;
    pend_d       = 1'b0;
    func_d       = func_q;
    row_d        = row_q;
    val_d        = val_q;
    span_d       = span_q;
    k_d          = k_q;
    scan_d       = scan_q;
    cnt_d        = cnt_q;
    mask_d       = mask_q;
    res_status_d = res_status_q;
    res_vout_d   = res_vout_q;
    mem_rd       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = row_addr;
    mem_wdata    = mask_w;
    case (state_q)
      ubi_pkg::ST_IDLE: begin
        if (in_acc) begin
          func_d = func_i;
          row_d  = row_id_i;
          val_d  = value_i;
          span_d = span_i;
        end
      end
      ubi_pkg::ST_DECODE: begin
        k_d          = '0;
        scan_d       = '0;
        cnt_d        = '0;
        mask_d       = mask_w;
        res_vout_d   = '0;
        res_status_d = ubi_pkg::STAT_OK;
        if (arg_err) begin
          res_status_d = ubi_pkg::STAT_ERR;
        end else if (func_q == ubi_pkg::FN_APPEND) begin
          mem_we      = 1'b1;
          mem_addr    = rows_used_q[AW-1:0];
          rows_used_d = rows_used_q + UW'(1);
        end else if (point_op) begin
          if (row_live) begin
            mem_rd = 1'b1;
          end else begin
            res_status_d = ubi_pkg::STAT_NONE;
          end
        end
      end
      ubi_pkg::ST_FIND: begin
        if (k_done) begin
          res_status_d = ubi_pkg::STAT_NONE;
        end else if (!k_hit) begin
          k_d = k_q + NW'(1);
        end
      end
      ubi_pkg::ST_APPLY: begin
        res_status_d = apply_status;
        mem_we       = apply_we;
        mem_wdata    = apply_word;
        if (func_q == ubi_pkg::FN_READ) res_vout_d = 5'(k_q);
      end
      ubi_pkg::ST_SCAN: begin
        // One row read issued per cycle; its word is tested in the next cycle.
        if (scan_q != rows_used_q) begin
          mem_rd   = 1'b1;
          mem_addr = scan_q[AW-1:0];
          scan_d   = scan_q + UW'(1);
        end
        pend_d = mem_rd;
        if (pend_q && (rd_data & mask_q) != '0) cnt_d = cnt_q + UW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ubi_pkg::ST_IDLE;
      encoding_mode_q <= 1'b0;
      cardinality_q   <= ubi_pkg::CARD_RESET;
      rows_used_q     <= '0;
      pend_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_used_q <= rows_used_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ubi_pkg::CFG_ENCODING: encoding_mode_q <= cfg_data_i[0];
          ubi_pkg::CFG_CARD:     cardinality_q   <= cfg_data_i;
          default:               cardinality_q   <= cardinality_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    row_q        <= row_d;
    val_q        <= val_d;
    span_q       <= span_d;
    k_q          <= k_d;
    scan_q       <= scan_d;
    cnt_q        <= cnt_d;
    mask_q       <= mask_d;
    res_status_q <= res_status_d;
    res_vout_q   <= res_vout_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_count_q  <= 13'(cnt_q);
      out_vout_q   <= res_vout_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign row_count_o = out_count_q;
  assign value_out_o = out_vout_q;

  `UBI_ASSERT_IMPL(a_rows_in_range, clk_i, rst_ni, 1'b1, int'(rows_used_q) <= ROWS)
  `UBI_ASSERT_IMPL(a_scan_bound, clk_i, rst_ni, state_q == ubi_pkg::ST_SCAN, scan_q <= rows_used_q)
  `UBI_ASSERT_NEXT(a_accept_decode, clk_i, rst_ni, in_acc, state_q == ubi_pkg::ST_DECODE)
  `UBI_ASSERT_NEXT(a_load_from_finish, clk_i, rst_ni, state_q != ubi_pkg::ST_FINISH && !out_valid_q, !out_valid_q)

endmodule

`default_nettype wire

// ----- tb/tb_updatable_bitmap_index.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the updatable bitmap index: a queued request driver, a
// result monitor and an in-house predictor of the row store and its counts.
// Depends on ubi_pkg and the updatable_bitmap_index block only.

module tb_updatable_bitmap_index;

  localparam int          ROWS      = 4096;
  localparam int          VALUES    = 32;
  localparam int unsigned MAX_CYCLE = 400000;
  localparam logic [2:0]  FN_RSVD6  = 3'd6;
  localparam logic [2:0]  FN_RSVD7  = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [11:0] row;
    logic [4:0]  value;
    logic [5:0]  span;
  } index_req_t;

  typedef struct {
    ubi_pkg::ubi_status_e status;
    logic [12:0]          count;
    logic [4:0]           value;
  } index_res_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [5:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i      = '0;
  logic [11:0] row_id_i    = '0;
  logic [4:0]  value_i     = '0;
  logic [5:0]  span_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [12:0] row_count_o;
  logic [4:0]  value_out_o;

  // predictor state and the configuration it runs under
  logic [31:0] row_word [ROWS];
  int unsigned rows_filled  = 0;
  logic        enc_range    = 1'b0;
  logic [5:0]  card_reg     = ubi_pkg::CARD_RESET;

  index_req_t  req_q [$];
  index_res_t  results_due [$];
  index_req_t  drv_req;
  index_req_t  seen_req;
  index_res_t  due_res;
  int unsigned rows_planned = 0;
  int unsigned req_gap      = 0;
  int unsigned res_hold     = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;
  bit          drv_busy     = 1'b0;
  bit          req_taken    = 1'b0;
  bit          res_taken    = 1'b0;
  bit          quiet        = 1'b0;

  updatable_bitmap_index #(
    .ROWS   (ROWS),
    .VALUES (VALUES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .row_id_i    (row_id_i),
    .value_i     (value_i),
    .span_i      (span_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .row_count_o (row_count_o),
    .value_out_o (value_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_card();
    if (card_reg < ubi_pkg::CARD_MIN) return ubi_pkg::CARD_MIN;
    if (card_reg > VALUES) return VALUES;
    return card_reg;
  endfunction

  function automatic int unsigned map_count();
    return enc_range ? eff_card() - 1 : eff_card();
  endfunction

  function automatic logic [31:0] bitmap_bit(int unsigned i);
    return (i < 32) ? (32'd1 << i) : 32'd0;
  endfunction

  function automatic logic [31:0] bitmap_span(int unsigned lo, int unsigned n);
    logic [31:0] m;
    m = '0;
    for (int unsigned i = 0; i < n; i++) m |= bitmap_bit(lo + i);
    return m;
  endfunction

  // lowest effective bitmap set in a row, -1 when none
  function automatic int lowest_value(logic [11:0] r);
    for (int unsigned i = 0; i < map_count(); i++)
      if (row_word[r][i]) return i;
    return -1;
  endfunction

  function automatic index_res_t apply_request(index_req_t rq);
    index_res_t  res;
    int unsigned card, nb, v, f, lo, hi, hits;
    int          from;
    logic [31:0] m, want;
    card = eff_card();
    nb   = map_count();
    v    = rq.value;
    hits = 0;
    res  = '{ubi_pkg::STAT_OK, 13'd0, 5'd0};
    case (rq.func)
      ubi_pkg::FN_APPEND: begin
        if (rows_filled >= ROWS || v >= card || (!enc_range && v >= nb)) begin
          res.status = ubi_pkg::STAT_ERR;
        end else begin
          row_word[rows_filled] = enc_range ? bitmap_span(v, nb - ((v < nb) ? v : nb))
                                            : bitmap_bit(v);
          rows_filled++;
        end
      end
      ubi_pkg::FN_UPDATE, ubi_pkg::FN_REMOVE, ubi_pkg::FN_READ: begin
        from = lowest_value(rq.row);
        if (rq.func == ubi_pkg::FN_UPDATE && (v >= card || (!enc_range && v >= nb))) begin
          res.status = ubi_pkg::STAT_ERR;
        end else if (from < 0) begin
          res.status = ubi_pkg::STAT_NONE;
        end else begin
          f = from;
          if (rq.func == ubi_pkg::FN_READ) begin
            res.value = 5'(f);
          end else if (rq.func == ubi_pkg::FN_UPDATE) begin
            if (v == f) begin
              res.status = ubi_pkg::STAT_NONE;
            end else if (!enc_range) begin
              if ((row_word[rq.row] & bitmap_bit(v)) != 0) res.status = ubi_pkg::STAT_NONE;
              else row_word[rq.row] ^= bitmap_bit(v) | bitmap_bit(f);
            end else begin
              // toggle the bitmaps between the old and the new value
              lo   = (v > f) ? f : v;
              hi   = (v > f) ? v : f;
              m    = bitmap_span(lo, hi - lo);
              want = (v > f) ? m : '0;
              if ((row_word[rq.row] & m) != want) res.status = ubi_pkg::STAT_NONE;
              else row_word[rq.row] ^= m;
            end
          end else if (!enc_range) begin
            row_word[rq.row] &= ~bitmap_bit(f);
          end else begin
            m = bitmap_span(f, nb - f);
            if ((row_word[rq.row] & m) != m) res.status = ubi_pkg::STAT_NONE;
            else row_word[rq.row] &= ~m;
          end
        end
      end
      ubi_pkg::FN_COUNT_VAL: begin
        if (v >= nb) begin
          res.status = ubi_pkg::STAT_ERR;
        end else begin
          for (int unsigned r = 0; r < rows_filled; r++)
            if ((row_word[r] & bitmap_bit(v)) != 0) hits++;
        end
      end
      ubi_pkg::FN_COUNT_SPAN: begin
        if (v + rq.span > nb) begin
          res.status = ubi_pkg::STAT_ERR;
        end else begin
          m = bitmap_span(v, rq.span);
          for (int unsigned r = 0; r < rows_filled; r++)
            if ((row_word[r] & m) != 0) hits++;
        end
      end
      default: res.status = ubi_pkg::STAT_ERR;
    endcase
    res.count = 13'(hits);
    return res;
  endfunction

  function automatic void queue_request(logic [2:0] fn, logic [11:0] row, logic [4:0] val,
                                        logic [5:0] spn);
    index_req_t rq;
    rq = '{fn, row, val, spn};
    // track the fill count so that later requests address rows that exist
    if (fn == ubi_pkg::FN_APPEND && rows_planned < ROWS && val < eff_card() &&
        (enc_range || val < map_count()))
      rows_planned++;
    req_q.push_back(rq);
  endfunction

  function automatic void queue_random();
    int unsigned card, nb, pick, lo;
    logic [11:0] row;
    card = eff_card();
    nb   = map_count();
    row  = (rows_planned == 0) ? 12'd0 : 12'($urandom_range(0, rows_planned - 1));
    pick = $urandom_range(0, 99);
    if (pick < 28)
      queue_request(ubi_pkg::FN_APPEND, 12'($urandom), 5'($urandom_range(0, card - 1)),
                    6'($urandom));
    else if (pick < 50)
      queue_request(ubi_pkg::FN_UPDATE, row, 5'($urandom_range(0, card - 1)), 6'($urandom));
    else if (pick < 60)
      queue_request(ubi_pkg::FN_REMOVE, row, 5'($urandom), 6'($urandom));
    else if (pick < 70)
      queue_request(ubi_pkg::FN_READ, row, 5'($urandom), 6'($urandom));
    else if (pick < 78)
      queue_request(ubi_pkg::FN_COUNT_VAL, 12'($urandom), 5'($urandom_range(0, nb - 1)),
                    6'($urandom));
    else if (pick < 86) begin
      lo = $urandom_range(0, nb - 1);
      queue_request(ubi_pkg::FN_COUNT_SPAN, 12'($urandom), 5'(lo),
                    6'($urandom_range(0, nb - lo)));
    end else
      queue_request(3'($urandom), 12'($urandom), 5'($urandom), 6'($urandom));
  endfunction

  function automatic int unsigned draw_wait();
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic write_reg(ubi_pkg::ubi_cfg_e idx, logic [5:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ubi_pkg::CFG_ENCODING) enc_range = data[0];
    else card_reg = data;
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || drv_busy || results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(logic mode, logic [5:0] card, bit calm);
    write_reg(ubi_pkg::CFG_ENCODING, {5'd0, mode});
    write_reg(ubi_pkg::CFG_CARD, card);
    quiet = calm;
    repeat (19) queue_random();
    wait_drained();
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        req_taken = 1'b0;
        drv_busy  = 1'b0;
        req_gap   = draw_wait();
      end
      if (!drv_busy && req_q.size() != 0) begin
        if (req_gap != 0) begin
          req_gap--;
        end else begin
          drv_req = req_q.pop_front();
          func_i   <= drv_req.func;
          row_id_i <= drv_req.row;
          value_i  <= drv_req.value;
          span_i   <= drv_req.span;
          drv_busy = 1'b1;
        end
      end
      in_valid_i <= drv_busy;
    end
  end

  // result back-pressure: hold stall for a randomly drawn wait after each result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 1'b0;
        res_hold  = draw_wait();
      end else if (res_hold != 0) begin
        res_hold--;
      end
      out_stall_i <= (res_hold != 0);
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen_req = '{func_i, row_id_i, value_i, span_i};
        results_due.push_back(apply_request(seen_req));
        req_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        res_taken = 1'b1;
        if (results_due.size() == 0) begin
          report_mismatch("result with no request, status", status_o, -1);
        end else begin
          due_res = results_due.pop_front();
          if (status_o !== due_res.status)
            report_mismatch("status", status_o, due_res.status);
          if (row_count_o !== due_res.count)
            report_mismatch("row_count", row_count_o, due_res.count);
          if (value_out_o !== due_res.value)
            report_mismatch("value_out", value_out_o, due_res.value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= MAX_CYCLE) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ROWS; i++) row_word[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // equality encoding, 32 bitmaps out of reset
    queue_request(ubi_pkg::FN_READ, 12'd0, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_COUNT_VAL, 12'd0, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd31, 6'd0);
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd9, 6'd0);
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd12, 6'd0);
    queue_request(ubi_pkg::FN_UPDATE, 12'd0, 5'd31, 6'd0);
    queue_request(ubi_pkg::FN_UPDATE, 12'd1, 5'd31, 6'd0);
    queue_request(ubi_pkg::FN_UPDATE, 12'd2, 5'd3, 6'd0);
    queue_request(ubi_pkg::FN_REMOVE, 12'd2, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_UPDATE, 12'd2, 5'd4, 6'd0);
    queue_request(ubi_pkg::FN_COUNT_SPAN, 12'd0, 5'd0, 6'd32);
    queue_request(ubi_pkg::FN_COUNT_SPAN, 12'd0, 5'd31, 6'd2);
    queue_request(ubi_pkg::FN_COUNT_SPAN, 12'd0, 5'd5, 6'd0);
    queue_request(FN_RSVD6, 12'hfff, 5'd31, 6'd63);
    queue_request(FN_RSVD7, 12'd0, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_READ, 12'hfff, 5'd0, 6'd0);
    wait_drained();

    // range encoding over rows written in equality form: inconsistent bits
    write_reg(ubi_pkg::CFG_ENCODING, 6'd1);
    write_reg(ubi_pkg::CFG_CARD, 6'd63);
    queue_request(ubi_pkg::FN_UPDATE, 12'd3, 5'd20, 6'd0);
    queue_request(ubi_pkg::FN_REMOVE, 12'd3, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd31, 6'd0);
    queue_request(ubi_pkg::FN_READ, 12'd4, 5'd0, 6'd0);
    wait_drained();

    // smallest range setting: a single bitmap
    write_reg(ubi_pkg::CFG_CARD, 6'd0);
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd1, 6'd0);
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd2, 6'd0);
    queue_request(ubi_pkg::FN_COUNT_VAL, 12'd0, 5'd1, 6'd0);
    queue_request(ubi_pkg::FN_COUNT_SPAN, 12'd0, 5'd0, 6'd1);
    wait_drained();

    run_phase(1'b0, 6'd1, 1'b0);
    run_phase(1'b1, 6'd33, 1'b0);
    run_phase(1'b0, 6'd13, 1'b1);
    run_phase(1'b1, 6'd7, 1'b0);
    run_phase(1'b0, 6'd63, 1'b0);
    run_phase(1'b1, 6'd2, 1'b0);

    // wide spans and edge rows back in equality encoding
    write_reg(ubi_pkg::CFG_ENCODING, 6'd0);
    write_reg(ubi_pkg::CFG_CARD, 6'd32);
    quiet = 1'b1;
    queue_request(ubi_pkg::FN_APPEND, 12'd0, 5'd3, 6'd0);
    queue_request(ubi_pkg::FN_COUNT_SPAN, 12'd0, 5'd0, 6'd32);
    queue_request(ubi_pkg::FN_COUNT_VAL, 12'd0, 5'd17, 6'd0);
    queue_request(ubi_pkg::FN_READ, 12'hfff, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_UPDATE, 12'hfff, 5'd30, 6'd0);
    queue_request(ubi_pkg::FN_REMOVE, 12'hfff, 5'd0, 6'd0);
    queue_request(ubi_pkg::FN_COUNT_SPAN, 12'd0, 5'd16, 6'd16);
    wait_drained();

    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/ubi_pkg.sv
src/ubi_row_store.sv
src/updatable_bitmap_index.sv
tb/tb_updatable_bitmap_index.sv
